// File: rtl/letter_palindrome_checker_top_macros.svh
// Assertion macros used by the checker file.
`ifndef LETTER_PALINDROME_CHECKER_TOP_MACROS_SVH
`define LETTER_PALINDROME_CHECKER_TOP_MACROS_SVH

// Implication in the same cycle, disabled while reset is held.
`define LPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the following cycle, disabled while reset is held.
`define LPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lpc_pkg.sv
`timescale 1ns / 1ps
package lpc_pkg;

  localparam int MaxLetters = 64;
  localparam int AddrW      = $clog2(MaxLetters);
  localparam int CountW     = $clog2(MaxLetters + 1);
  localparam int InDataW    = 8;
  localparam int OutFieldW  = 2 + CountW;
  localparam int OutDataW   = ((OutFieldW + 7) / 8) * 8;

  localparam logic [7:0] CharUpFirst = 8'd65;
  localparam logic [7:0] CharUpLast  = 8'd90;
  localparam logic [7:0] CharLoFirst = 8'd97;
  localparam logic [7:0] CharLoLast  = 8'd122;
  localparam logic [7:0] CaseMask    = 8'hDF;

  typedef struct packed {
    logic push;
    logic start;
    logic rd;
    logic emit;
  } lpc_cmd_t;

  typedef struct packed {
    logic rd_more;
    logic rd_vld;
  } lpc_sts_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CharUpFirst) && (c <= CharUpLast)) ||
           ((c >= CharLoFirst) && (c <= CharLoLast));
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    return c & CaseMask;
  endfunction

endpackage

// File: rtl/lpc_ctrl.sv
`timescale 1ns / 1ps
module lpc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output lpc_pkg::lpc_cmd_t cmd,
  input  lpc_pkg::lpc_sts_t sts
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic       in_acc;
  logic       out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_vld_r || out_tready;

  always_comb begin
    state_nxt   = state_r;
    out_vld_nxt = out_vld_r && !out_tready;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tlast) begin
            cmd.start = 1'b1;
            state_nxt = ST_CHECK;
          end else begin
            cmd.push = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        cmd.rd = sts.rd_more;
        if (!sts.rd_more && !sts.rd_vld) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.emit    = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

// File: rtl/lpc_dp.sv
`timescale 1ns / 1ps
module lpc_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [7:0]                     char_in,
  input  lpc_pkg::lpc_cmd_t              cmd,
  output lpc_pkg::lpc_sts_t              sts,
  output logic [lpc_pkg::OutDataW-1:0]   res_data
);

  logic [7:0]                mem [lpc_pkg::MaxLetters];
  logic [lpc_pkg::CountW-1:0] count_r, count_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [lpc_pkg::CountW-1:0] idx_r;
  logic [lpc_pkg::CountW-1:0] half;
  logic [lpc_pkg::CountW-1:0] mirror;
  logic [7:0]                rd_a_r, rd_b_r;
  logic                      rd_vld_r;
  logic                      mismatch_r;
  logic                      res_pal_r;
  logic [lpc_pkg::CountW-1:0] res_cnt_r;
  logic                      res_ovf_r;
  logic                      letter;
  logic                      has_room;

  assign letter   = lpc_pkg::is_letter(char_in);
  assign has_room = (count_r < lpc_pkg::CountW'(lpc_pkg::MaxLetters));
  assign half     = count_r >> 1;
  assign mirror   = count_r - lpc_pkg::CountW'(1) - idx_r;

  assign sts.rd_more = (idx_r < half);
  assign sts.rd_vld  = rd_vld_r;

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (cmd.emit) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (cmd.push && letter) begin
      if (has_room) begin
        count_nxt = count_r + lpc_pkg::CountW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      ovf_r      <= 1'b0;
      rd_vld_r   <= 1'b0;
      idx_r      <= '0;
      mismatch_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      rd_vld_r <= cmd.rd;
      if (cmd.start) begin
        idx_r      <= '0;
        mismatch_r <= 1'b0;
      end else begin
        if (cmd.rd) begin
          idx_r <= idx_r + lpc_pkg::CountW'(1);
        end
        if (rd_vld_r && (rd_a_r != rd_b_r)) begin
          mismatch_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && letter && has_room) begin
      mem[count_r[lpc_pkg::AddrW-1:0]] <= lpc_pkg::fold_upper(char_in);
    end
    if (cmd.rd) begin
      rd_a_r <= mem[idx_r[lpc_pkg::AddrW-1:0]];
      rd_b_r <= mem[mirror[lpc_pkg::AddrW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_pal_r <= !ovf_r && !mismatch_r;
      res_cnt_r <= count_r;
      res_ovf_r <= ovf_r;
    end
  end

  assign res_data = {{(lpc_pkg::OutDataW - lpc_pkg::OutFieldW){1'b0}},
                     res_ovf_r, res_cnt_r, res_pal_r};

endmodule

// File: rtl/letter_palindrome_checker_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Payload
// in_      slave      tdata[7:0] character, tlast end_of_phrase
// out_     master     tdata[0] is_palindrome, [7:1] letter_count, [8] overflow
//
// A letter or skipped byte produces no result item and is taken only while idle.
// An end item starts the check: the letter memory reads one mirrored pair per cycle
// until half the stored letters are compared, then the result waits for a free output.
// Reset is synchronous and active low and clears the count, the overflow
// flag and the output valid; the letter memory is not cleared.
// in_tready is low from an end item until its result enters the output register.
module letter_palindrome_checker_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [lpc_pkg::InDataW-1:0]  in_tdata,   // [7:0] character
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [lpc_pkg::OutDataW-1:0] out_tdata   // is_palindrome, letter_count, overflow
);

  lpc_pkg::lpc_cmd_t cmd;
  lpc_pkg::lpc_sts_t sts;

  lpc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  lpc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .char_in  (in_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .res_data (out_tdata)
  );

endmodule

// File: rtl/lpc_checker.sv
`timescale 1ns / 1ps
`include "letter_palindrome_checker_top_macros.svh"
module lpc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         in_tlast,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [lpc_pkg::OutDataW-1:0] out_tdata
);

  `LPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "Result item dropped while stalled.")
  `LPC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata), "Result item changed while stalled.")
  `LPC_ASSERT_NOW(a_ovf_not_pal, clk, rst_n, out_tvalid && out_tdata[lpc_pkg::CountW + 1], !out_tdata[0], "Overflowed phrase reported as palindrome.")
  `LPC_ASSERT_NOW(a_count_cap, clk, rst_n, out_tvalid, out_tdata[lpc_pkg::CountW:1] <= lpc_pkg::CountW'(lpc_pkg::MaxLetters), "Letter count above capacity.")
  `LPC_ASSERT_NEXT(a_end_stalls, clk, rst_n, in_tvalid && in_tready && in_tlast, !in_tready, "Input taken during a phrase check.")

endmodule

bind letter_palindrome_checker_top lpc_checker u_lpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: bench/letter_palindrome_checker_top_tb.sv
`timescale 1ns / 1ps
module letter_palindrome_checker_top_tb;

  localparam int CycleLimit   = 400000;
  localparam int PhaseItems   = 570;
  localparam int DrainCycles  = 3 * lpc_pkg::MaxLetters;

  typedef struct packed {
    logic       pal;
    logic [6:0] cnt;
    logic       ovf;
  } phrase_verdict_t;

  // A phrase is fill copies of fill_char followed by the len bytes of text,
  // read from the left, then an end item.
  typedef struct packed {
    logic [95:0]     text;
    int              len;
    int              fill;
    logic [7:0]      fill_char;
    bit              typed;
    phrase_verdict_t verdict;
  } phrase_row_t;

  localparam int NumRows = 11;
  localparam phrase_row_t DirectedRows [NumRows] = '{
    '{96'd0, 0, 0, 8'd0, 1'b1, '{1'b1, 7'd0, 1'b0}},
    '{"a", 1, 0, 8'd0, 1'b1, '{1'b1, 7'd1, 1'b0}},
    '{{8'h00, 8'hFF, "@[`{"}, 6, 0, 8'd0, 1'b1, '{1'b1, 7'd0, 1'b0}},
    '{"AzZa", 4, 0, 8'd0, 1'b0, '{1'b0, 7'd0, 1'b0}},
    '{"Race car!", 9, 0, 8'd0, 1'b0, '{1'b0, 7'd0, 1'b0}},
    '{"abca", 4, 0, 8'd0, 1'b0, '{1'b0, 7'd0, 1'b0}},
    '{"Ab", 2, 0, 8'd0, 1'b1, '{1'b0, 7'd2, 1'b0}},
    '{96'd0, 0, 64, "M", 1'b0, '{1'b0, 7'd0, 1'b0}},
    '{"x", 1, 70, "k", 1'b1, '{1'b0, 7'd64, 1'b1}},
    '{{8'h00, "~"}, 2, 64, "b", 1'b0, '{1'b0, 7'd0, 1'b0}},
    '{"z", 1, 0, 8'd0, 1'b1, '{1'b1, 7'd1, 1'b0}}
  };

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [lpc_pkg::InDataW-1:0]  in_tdata;
  logic                         in_tlast;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [lpc_pkg::OutDataW-1:0] out_tdata;

  logic [7:0]      letters_held [lpc_pkg::MaxLetters];
  int              letters_kept;
  bit              letters_dropped;
  phrase_verdict_t verdicts_pending [$];
  phrase_verdict_t verdict_due;
  logic [7:0]      phrase_bytes [$];
  int              send_idle_pct;
  int              recv_idle_pct;
  int              items_sent;
  int              errors = 0;
  int              cycle_count = 0;

  letter_palindrome_checker_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (verdicts_pending.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, out_tdata);
        errors++;
      end else begin
        verdict_due = verdicts_pending.pop_front();
        if (out_tdata[0] !== verdict_due.pal) begin
          $display("%0t: is_palindrome expected %0d actual %0d",
                   $time, verdict_due.pal, out_tdata[0]);
          errors++;
        end
        if (out_tdata[7:1] !== verdict_due.cnt) begin
          $display("%0t: letter_count expected %0d actual %0d",
                   $time, verdict_due.cnt, out_tdata[7:1]);
          errors++;
        end
        if (out_tdata[8] !== verdict_due.ovf) begin
          $display("%0t: overflow expected %0d actual %0d",
                   $time, verdict_due.ovf, out_tdata[8]);
          errors++;
        end
      end
    end
  end

  function automatic logic [7:0] upper_letter(input logic [7:0] c);
    if (c >= 8'd65 && c <= 8'd90) return c;
    if (c >= 8'd97 && c <= 8'd122) return c - 8'd32;
    return 8'd0;
  endfunction

  function automatic bit judge_phrase(input logic [7:0] c, input logic last,
                                      output phrase_verdict_t v);
    logic [7:0] up;
    bit         mirrored;
    mirrored = 1'b1;
    if (!last) begin
      up = upper_letter(c);
      if (up != 8'd0) begin
        if (letters_kept < lpc_pkg::MaxLetters) begin
          letters_held[letters_kept] = up;
          letters_kept++;
        end else begin
          letters_dropped = 1'b1;
        end
      end
      return 1'b0;
    end
    for (int i = 0; i < letters_kept / 2; i++) begin
      if (letters_held[i] != letters_held[letters_kept - 1 - i]) mirrored = 1'b0;
    end
    v.pal = mirrored && !letters_dropped;
    v.cnt = letters_kept[6:0];
    v.ovf = letters_dropped;
    letters_kept = 0;
    letters_dropped = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_item(input logic [7:0] c, input logic last,
                           input bit typed, input phrase_verdict_t typed_verdict);
    phrase_verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (judge_phrase(c, last, v)) verdicts_pending.push_back(typed ? typed_verdict : v);
  endtask

  function automatic logic [7:0] non_letter();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (upper_letter(c) != 8'd0);
    return c;
  endfunction

  task automatic build_phrase();
    int         n;
    int         kind;
    int         r;
    logic [7:0] word [72];
    phrase_bytes.delete();
    r = $urandom_range(99);
    if (r < 70) n = $urandom_range(16);
    else if (r < 85) n = $urandom_range(59, 17);
    else if (r < 93) n = $urandom_range(64, 60);
    else n = $urandom_range(72, 65);
    kind = $urandom_range(99);
    if (kind >= 90) begin
      n = $urandom_range(20);
      for (int i = 0; i < n; i++) phrase_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    for (int i = 0; i < n; i++) word[i] = 8'd65 + 8'($urandom_range(25));
    if (kind < 75) begin
      for (int i = 0; i < n / 2; i++) word[n - 1 - i] = word[i];
    end
    if (kind >= 55 && kind < 75 && n >= 2) begin
      r = $urandom_range(n / 2 - 1);
      word[r] = (word[r] == 8'd90) ? 8'd65 : word[r] + 8'd1;
    end
    for (int i = 0; i < n; i++) begin
      while ($urandom_range(99) < 20) phrase_bytes.push_back(non_letter());
      phrase_bytes.push_back($urandom_range(1) ? (word[i] | 8'h20) : word[i]);
    end
    if ($urandom_range(3) == 0) phrase_bytes.push_back(non_letter());
  endtask

  task automatic run_random_phase(input int sender_pct, input int receiver_pct);
    int target;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    target = items_sent + PhaseItems;
    while (items_sent < target) begin
      build_phrase();
      foreach (phrase_bytes[i]) send_item(phrase_bytes[i], 1'b0, 1'b0, '0);
      send_item(8'($urandom_range(255)), 1'b1, 1'b0, '0);
    end
  endtask

  initial begin
    phrase_row_t row;
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tlast        = 1'b0;
    letters_kept    = 0;
    letters_dropped = 1'b0;
    send_idle_pct   = 19;
    recv_idle_pct   = 55;
    items_sent      = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NumRows; r++) begin
      row = DirectedRows[r];
      for (int i = 0; i < row.fill; i++) send_item(row.fill_char, 1'b0, 1'b0, '0);
      for (int i = 0; i < row.len; i++) begin
        send_item(row.text[8 * (row.len - 1 - i) +: 8], 1'b0, 1'b0, '0);
      end
      send_item(8'($urandom_range(255)), 1'b1, row.typed, row.verdict);
    end

    run_random_phase(19, 55);
    run_random_phase(55, 19);
    run_random_phase(0, 0);
    in_tvalid <= 1'b0;

    while (verdicts_pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
